>>> rtl/brlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlt_pkg
// shared types and constants of the byte-range lock table
// ----------------------------------------------------------------------------
package brlt_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam logic [1:0] MODE_LOCK   = 2'd0;
  localparam logic [1:0] MODE_UNLOCK = 2'd1;
  localparam logic [1:0] MODE_TEST   = 2'd2;
  localparam logic [1:0] MODE_CLOSE  = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_GRANTED = 3'd1;
  localparam logic [2:0] ST_NOT_LOCKED  = 3'd2;
  localparam logic [2:0] ST_CONFLICT    = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;

  localparam logic LOCK_RD = 1'b0;

  localparam logic [0:0] REG_SERVER = 1'd0;
  localparam logic [0:0] REG_TREE   = 1'd1;

  typedef struct packed {
    logic [31:0] file;
    logic [31:0] server;
    logic [15:0] pid;
    logic [15:0] tree;
    logic [15:0] hnd;
    logic [63:0] start;
    logic [63:0] size;
    logic        wr;
  } lock_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;   // capture request
    logic clr_idx;    // restart scan pointers
    logic step;       // advance read pointer, copy when compacting
    logic append;     // write request at end
    logic remove;     // drop current entry (do not copy)
    logic finish;     // commit compacted count
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       scan_done;
    logic       full;
    logic       hit_conflict;
    logic       hit_match;
    logic       hit_test;
    logic       hit_close;
    logic [1:0] mode;
  } dp_sts_t;

endpackage

>>> rtl/brlt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlt_datapath
// lock table storage, entry compare and in-place compaction
// ----------------------------------------------------------------------------
module brlt_datapath #(
  parameter int unsigned ENTRIES = brlt_pkg::ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  brlt_pkg::dp_cmd_t cmd_i,
  output brlt_pkg::dp_sts_t sts_o,
  input  logic [1:0]        mode_i,
  input  logic [31:0]       file_id_i,
  input  logic [15:0]       process_id_i,
  input  logic [15:0]       handle_i,
  input  logic [63:0]       range_start_i,
  input  logic [63:0]       range_size_i,
  input  logic              is_write_i,
  input  logic [31:0]       server_id_i,
  input  logic [15:0]       tree_id_i
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  brlt_pkg::lock_t tab_q [ENTRIES];
  brlt_pkg::lock_t req_q;
  logic [1:0]      mode_q;
  logic [CW-1:0]   cnt_q;
  logic [CW-1:0]   rd_q;
  logic [CW-1:0]   wr_q;
  brlt_pkg::lock_t e;
  logic            same_own, disj, fmatch, confl_base;
  logic [IW-1:0]   rd_idx, wr_idx, cnt_idx;

  assign rd_idx  = rd_q[IW-1:0];
  assign wr_idx  = wr_q[IW-1:0];
  assign cnt_idx = cnt_q[IW-1:0];
  assign e = tab_q[rd_idx];

  assign same_own = (e.server == req_q.server) && (e.pid == req_q.pid) &&
                    (e.tree == req_q.tree) && (e.hnd == req_q.hnd);
  assign disj = (e.start >= req_q.start + req_q.size) ||
                (req_q.start >= e.start + e.size);
  assign fmatch = (e.file == req_q.file);
  assign confl_base = fmatch && !((e.wr == brlt_pkg::LOCK_RD) &&
                      (req_q.wr == brlt_pkg::LOCK_RD)) && !disj;

  always_comb begin
    sts_o.scan_done    = (rd_q >= cnt_q);
    sts_o.full         = (cnt_q == CW'(ENTRIES));
    sts_o.hit_conflict = confl_base &&
                         !(same_own && (req_q.wr == brlt_pkg::LOCK_RD));
    sts_o.hit_test     = confl_base && !same_own;
    sts_o.hit_match    = fmatch && same_own && (e.start == req_q.start) &&
                         (e.size == req_q.size);
    sts_o.hit_close    = fmatch && (e.tree == req_q.tree) &&
                         (e.server == req_q.server) && (e.hnd == req_q.hnd);
    sts_o.mode         = mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rd_q   <= '0;
      wr_q   <= '0;
      mode_q <= brlt_pkg::MODE_LOCK;
    end else begin
      if (cmd_i.load_req) begin
        mode_q <= mode_i;
      end
      if (cmd_i.clr_idx) begin
        rd_q <= '0;
        wr_q <= '0;
      end else if (cmd_i.step) begin
        rd_q <= rd_q + CW'(1);
        if (!cmd_i.remove) begin
          wr_q <= wr_q + CW'(1);
        end
      end
      if (cmd_i.append) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.finish) begin
        cnt_q <= wr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= '{file: file_id_i, server: server_id_i, pid: process_id_i,
                 tree: tree_id_i, hnd: handle_i, start: range_start_i,
                 size: range_size_i, wr: is_write_i};
    end
    if (cmd_i.append) begin
      tab_q[cnt_idx] <= req_q;
    end else if (cmd_i.step && !cmd_i.remove && (wr_q != rd_q)) begin
      tab_q[wr_idx] <= e;
    end
  end

endmodule

>>> rtl/brlt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlt_ctrl
// request sequencer: scan, decide, compact, report
// ----------------------------------------------------------------------------
module brlt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output brlt_pkg::dp_cmd_t cmd_o,
  input  brlt_pkg::dp_sts_t sts_i
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COPY, S_DONE} state_e;

  state_e     state_q;
  logic [2:0] status_q;
  logic       rm_q;    // unlock already removed one
  logic       in_acc;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_o;
  assign in_acc      = in_valid_i && in_ready_o;
  assign status_o    = status_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load_req = in_acc;
    cmd_o.clr_idx  = in_acc;
    if (state_q == S_SCAN) begin
      if (!sts_i.scan_done) begin
        case (sts_i.mode)
          brlt_pkg::MODE_LOCK: cmd_o.step = !sts_i.hit_conflict;
          brlt_pkg::MODE_TEST: cmd_o.step = !sts_i.hit_test;
          brlt_pkg::MODE_UNLOCK: begin
            cmd_o.step   = 1'b1;
            cmd_o.remove = sts_i.hit_match && !rm_q;
          end
          default: begin
            cmd_o.step   = 1'b1;
            cmd_o.remove = sts_i.hit_close;
          end
        endcase
      end else begin
        cmd_o.append = (sts_i.mode == brlt_pkg::MODE_LOCK) && !sts_i.full;
        cmd_o.finish = (sts_i.mode == brlt_pkg::MODE_UNLOCK) ||
                       (sts_i.mode == brlt_pkg::MODE_CLOSE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= brlt_pkg::ST_OK;
      rm_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (out_valid_o && out_ready_i) begin
            out_valid_o <= 1'b0;
          end
          if (in_acc) begin
            rm_q    <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts_i.scan_done) begin
            case (sts_i.mode)
              brlt_pkg::MODE_LOCK:
                status_q <= sts_i.full ? brlt_pkg::ST_FULL : brlt_pkg::ST_OK;
              brlt_pkg::MODE_UNLOCK:
                status_q <= rm_q ? brlt_pkg::ST_OK : brlt_pkg::ST_NOT_LOCKED;
              default: status_q <= brlt_pkg::ST_OK;
            endcase
            state_q <= S_DONE;
          end else if ((sts_i.mode == brlt_pkg::MODE_LOCK) && sts_i.hit_conflict) begin
            status_q <= brlt_pkg::ST_NOT_GRANTED;
            state_q  <= S_DONE;
          end else if ((sts_i.mode == brlt_pkg::MODE_TEST) && sts_i.hit_test) begin
            status_q <= brlt_pkg::ST_CONFLICT;
            state_q  <= S_DONE;
          end else if (cmd_o.remove && (sts_i.mode == brlt_pkg::MODE_UNLOCK)) begin
            rm_q <= 1'b1;
          end
        end
        S_COPY: state_q <= S_DONE;
        S_DONE: begin
          out_valid_o <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/byte_range_lock_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_range_lock_table
// byte-range lock table with lock, unlock, test and close requests
// ----------------------------------------------------------------------------
// channel  direction  signals
// request  in         in_valid_i / in_ready_o, request fields
// result   out        out_valid_o / out_ready_i, status_o
// config   in         cfg_we_i, cfg_idx_i, cfg_data_i
//
// one word in flight; the status word is valid after the one-entry-per-cycle scan
// that also compacts the table in place, earlier when lock or test stops at the
// first clash.
// no clearing pass after reset: the fill count marks the valid entries.
// a pending result blocks the next request until it is taken.
// ----------------------------------------------------------------------------
module byte_range_lock_table #(
  parameter int unsigned ENTRIES = brlt_pkg::ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] file_id_i,
  input  logic [15:0] process_id_i,
  input  logic [15:0] handle_i,
  input  logic [63:0] range_start_i,
  input  logic [63:0] range_size_i,
  input  logic        is_write_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o
);

  logic [31:0]       server_q;
  logic [15:0]       tree_q;
  brlt_pkg::dp_cmd_t cmd;
  brlt_pkg::dp_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_q <= '0;
      tree_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        brlt_pkg::REG_SERVER: server_q <= cfg_data_i;
        brlt_pkg::REG_TREE:   tree_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  brlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  brlt_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (mode_i),
    .file_id_i     (file_id_i),
    .process_id_i  (process_id_i),
    .handle_i      (handle_i),
    .range_start_i (range_start_i),
    .range_size_i  (range_size_i),
    .is_write_i    (is_write_i),
    .server_id_i   (server_q),
    .tree_id_i     (tree_q)
  );

endmodule
